// ----- src/blist_pkg.sv -----
package blist_pkg;

  // List depth and the widths that follow from it.
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W = 5;
  // Width wide enough to compare a request position against the count.
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_AT    = 3'd5,
    ACT_SEARCH    = 3'd6
  } action_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [POS_W-1:0]   position;
  } in_word_t;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] found_position;
    logic [POS_W-1:0] entry_count;
  } out_word_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             en;
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] slot;
    logic [31:0]      value;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

endpackage

// ----- src/blist_cell.sv -----
module blist_cell (
  input  logic                   clk,
  input  logic [blist_pkg::IDX_W-1:0] idx,
  input  blist_pkg::cell_cmd_t   cmd,
  input  logic [31:0]            left_value,
  input  logic [31:0]            right_value,
  output logic [31:0]            value_o,
  output logic                   match_o
);
  import blist_pkg::*;

  logic [31:0] value_r;
  logic [31:0] value_nxt;
  logic        match_r;
  logic        match_nxt;

  // Insert takes the new word at the slot and shifts the tail one cell back;
  // delete pulls the tail one cell forward over the slot.
  always_comb begin
    value_nxt = value_r;
    if (cmd.en && cmd.ins && (idx == cmd.slot)) begin
      value_nxt = cmd.value;
    end else if (cmd.en && cmd.ins && (idx > cmd.slot)) begin
      value_nxt = left_value;
    end else if (cmd.en && cmd.del && (idx >= cmd.slot)) begin
      value_nxt = right_value;
    end
  end

  // A cell matches only while it lies inside the occupied part of the list.
  always_comb begin
    match_nxt = match_r;
    if (cmd.en) begin
      match_nxt = (value_r == cmd.value) && (CNT_W'(idx) < cmd.count);
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    match_r <= match_nxt;
  end

  assign value_o = value_r;
  assign match_o = match_r;

endmodule

// ----- src/bounded_ordered_list.sv -----
// Channel | Direction | Word type            | Handshake
// in_     | input     | blist_pkg::in_word_t  | in_valid, in_stall
// out_    | output    | blist_pkg::out_word_t | out_valid, out_stall
//
// A request is applied to the cell chain in the cycle it is accepted; all
// cells shift and compare together. The first match is then resolved and
// loaded into the output register once free; a new request waits until then.
// Reset (rst_n low, synchronous) empties the list; cell contents are not reset.
// A stalled result sits in the output register while the next request enters.
module bounded_ordered_list (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  blist_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output blist_pkg::out_word_t out_word
);
  import blist_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             pend_valid_r;
  logic             pend_valid_nxt;
  logic             pend_ok_r;
  logic             pend_search_r;
  logic [CNT_W-1:0] pend_count_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_word_t        out_word_r;
  out_word_t        out_word_nxt;

  logic             in_fire;
  logic             out_load;
  logic             req_ok;
  cell_cmd_t        cmd;
  logic [CMP_W-1:0] pos_e;
  logic [CMP_W-1:0] cnt_e;
  logic             full;
  logic             empty;

  logic [31:0]            cell_value [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match;
  logic [POS_W-1:0]       found_pos;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = pend_valid_r;
  assign out_load = pend_valid_r && (!out_valid_r || !out_stall);

  // Decode the request into a shift command for the chain.
  always_comb begin
    pos_e     = CMP_W'(in_word.position);
    cnt_e     = CMP_W'(count_r);
    full      = (count_r == CNT_W'(MAX_ENTRIES));
    empty     = (count_r == '0);
    req_ok    = 1'b0;
    cmd.en    = in_fire;
    cmd.ins   = 1'b0;
    cmd.del   = 1'b0;
    cmd.slot  = '0;
    cmd.value = in_word.value;
    cmd.count = count_r;
    case (in_word.action)
      ACT_INS_FRONT: begin
        req_ok = !full;
      end
      ACT_INS_BACK: begin
        req_ok   = !full;
        cmd.slot = IDX_W'(count_r);
      end
      ACT_INS_AT: begin
        req_ok   = !full && (pos_e != '0) && (pos_e <= cnt_e + CMP_W'(1));
        cmd.slot = IDX_W'(pos_e - CMP_W'(1));
      end
      ACT_DEL_FRONT: begin
        req_ok = !empty;
      end
      ACT_DEL_BACK: begin
        req_ok   = !empty;
        cmd.slot = IDX_W'(count_r - CNT_W'(1));
      end
      ACT_DEL_AT: begin
        req_ok   = (pos_e != '0) && (pos_e <= cnt_e);
        cmd.slot = IDX_W'(pos_e - CMP_W'(1));
      end
      default: begin
        req_ok = 1'b0;
      end
    endcase
    if (in_word.action == ACT_INS_FRONT || in_word.action == ACT_INS_BACK ||
        in_word.action == ACT_INS_AT) begin
      cmd.ins = req_ok;
    end
    if (in_word.action == ACT_DEL_FRONT || in_word.action == ACT_DEL_BACK ||
        in_word.action == ACT_DEL_AT) begin
      cmd.del = req_ok;
    end
  end

  // Occupancy follows the command.
  always_comb begin
    count_nxt = count_r;
    if (cmd.en && cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.en && cmd.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // The chain of cells holding the list, front at cell zero.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [31:0] left_v;
    logic [31:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_v = cell_value[i];
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
    end
    blist_cell u_cell (
      .clk         (clk),
      .idx         (IDX_W'(i)),
      .cmd         (cmd),
      .left_value  (left_v),
      .right_value (right_v),
      .value_o     (cell_value[i]),
      .match_o     (match[i])
    );
  end

  // First matching cell, scanned from the back so the front one wins.
  always_comb begin
    found_pos = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_pos = POS_W'(i + 1);
      end
    end
  end

  // Result word for the output register.
  always_comb begin
    out_word_nxt = out_word_r;
    if (out_load) begin
      out_word_nxt.entry_count = POS_W'(pend_count_r);
      if (pend_search_r) begin
        out_word_nxt.ok             = |match;
        out_word_nxt.found_position = found_pos;
      end else begin
        out_word_nxt.ok             = pend_ok_r;
        out_word_nxt.found_position = '0;
      end
    end
  end

  // Handshake state for the pending and output stages.
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (in_fire) begin
      pend_valid_nxt = 1'b1;
    end else if (out_load) begin
      pend_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_ok_r     <= req_ok;
      pend_search_r <= (in_word.action == ACT_SEARCH);
      pend_count_r  <= count_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  // The list never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above list depth");

  // Occupancy moves only when a request is taken.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(count_r))
    else $error("entry count changed without a request");

  // An accepted request always leaves a pending result behind it.
  a_pend_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_valid_r)
    else $error("accepted request has no pending result");

  // A pending result moves to the output only while the output is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("output overwritten while stalled");
`endif

endmodule
